// ----- rtl/ujw_pkg.sv -----
package ujw_pkg;

  typedef struct packed {
    logic        action;
    logic [20:0] code_point;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic        error;
    logic [15:0] bytes_used;
  } out_word_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      n_m1;
    logic            error;
    logic [15:0]     first_used;
  } entry_t;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  localparam logic CFG_ESCAPE_MODE     = 1'b0;
  localparam logic CFG_BUFFER_CAPACITY = 1'b1;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;
  localparam logic [20:0] MAX_CP         = 21'h10FFFF;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_BS        = 8'h08;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] LETTER_B       = 8'h62;
  localparam logic [7:0] LETTER_F       = 8'h66;
  localparam logic [7:0] LETTER_R       = 8'h72;
  localparam logic [7:0] LETTER_N       = 8'h6E;
  localparam logic [7:0] LETTER_T       = 8'h74;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

endpackage

// ----- rtl/ujw_front.sv -----
module ujw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ujw_pkg::in_word_t in_word,
  input  logic              escape_mode,
  input  logic [15:0]       buffer_capacity,
  output logic              push,
  output ujw_pkg::entry_t   push_entry
);
  import ujw_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] room;
  logic [20:0] cp;
  logic [7:0]  letter;
  logic [3:0][7:0] enc;
  logic [2:0]  n;
  logic        err;
  logic        accept;

  assign cp     = in_word.code_point;
  assign accept = in_valid && !in_stall;
  assign room   = buffer_capacity - byte_count;

  always_comb begin
    letter = 8'd0;
    if (escape_mode && cp[20:8] == 13'd0) begin
      case (cp[7:0])
        CHAR_QUOTE:     letter = CHAR_QUOTE;
        CHAR_BACKSLASH: letter = CHAR_BACKSLASH;
        CHAR_BS:        letter = LETTER_B;
        CHAR_FF:        letter = LETTER_F;
        CHAR_CR:        letter = LETTER_R;
        CHAR_LF:        letter = LETTER_N;
        CHAR_TAB:       letter = LETTER_T;
        default:        letter = 8'd0;
      endcase
    end
  end

  always_comb begin
    enc = '0;
    n   = 3'd4;
    if (letter != 8'd0) begin
      enc[0] = CHAR_BACKSLASH;
      enc[1] = letter;
      n      = 3'd2;
    end else if (cp < 21'h80) begin
      enc[0] = {1'b0, cp[6:0]};
      n      = 3'd1;
    end else if (cp < 21'h800) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n      = 3'd2;
    end else if (cp < 21'h10000) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n      = 3'd3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n      = 3'd4;
    end
  end

  assign err = (byte_count >= buffer_capacity) || (cp > MAX_CP) ||
               ({13'd0, n} > room);

  assign push = accept && in_word.action == ACTION_WRITE;

  always_comb begin
    if (err) begin
      push_entry.bytes      = '0;
      push_entry.n_m1       = 2'd0;
      push_entry.error      = 1'b1;
      push_entry.first_used = byte_count;
    end else begin
      push_entry.bytes      = enc;
      push_entry.n_m1       = 2'(n - 3'd1);
      push_entry.error      = 1'b0;
      push_entry.first_used = byte_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 16'd0;
    end else if (accept) begin
      if (in_word.action == ACTION_CLEAR) begin
        byte_count <= 16'd0;
      end else if (!err) begin
        byte_count <= byte_count + {13'd0, n};
      end
    end
  end

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.action == ACTION_CLEAR |=> byte_count == 16'd0)
    else $error("count not zero after clear");

  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    push && err |=> byte_count == $past(byte_count))
    else $error("count moved on refused word");

endmodule

// ----- rtl/ujw_queue.sv -----
module ujw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ujw_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output ujw_pkg::entry_t head
);
  import ujw_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/ujw_back.sv -----
module ujw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ujw_pkg::entry_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ujw_pkg::out_word_t out_word
);
  import ujw_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !out_valid || !out_stall;
  assign at_last = idx == head.n_m1;
  assign pop     = load && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_word.out_byte   <= head.bytes[idx];
      out_word.last_byte  <= at_last;
      out_word.error      <= head.error;
      out_word.bytes_used <= head.first_used + {14'd0, idx};
    end
  end

  a_mid_has_head: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> head_valid)
    else $error("byte index set with empty queue");

endmodule

// ----- rtl/utf8_json_escape_byte_writer.sv -----
// Takes one code point word per cycle while its four-entry queue has room and
// emits one byte word per cycle while out_stall is low from a registered
// output stage: a code point yields one byte word per UTF-8 or escape byte
// (one to four), a refused code point yields one error word, a clear none.
// The output stage sets the sustained rate; byte count updates when a word
// is taken, so the input side runs ahead of the output by up to the queue.
module utf8_json_escape_byte_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ujw_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ujw_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import ujw_pkg::*;

  logic        escape_mode;
  logic [15:0] buffer_capacity;
  logic        push;
  logic        pop;
  logic        full;
  logic        head_valid;
  entry_t      push_entry;
  entry_t      head;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode     <= 1'b0;
      buffer_capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPE_MODE:     escape_mode     <= cfg_data[0];
        CFG_BUFFER_CAPACITY: buffer_capacity <= cfg_data;
        default:             escape_mode     <= escape_mode;
      endcase
    end
  end

  assign in_stall = full;

  ujw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .escape_mode     (escape_mode),
    .buffer_capacity (buffer_capacity),
    .push            (push),
    .push_entry      (push_entry)
  );

  ujw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  ujw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.error |-> out_word.last_byte && out_word.out_byte == 8'd0)
    else $error("error word not a lone zero byte");

endmodule
